// ===== hw/rtl/crdc_pkg.sv =====
// Shared types, constants and the arctangent table of the CORDIC converter.
package crdc_pkg;

   // Field widths of the request and response.
   localparam int DATA_WIDTH   = 16;
   localparam int RADIUS_WIDTH = DATA_WIDTH - 1;
   localparam int ANGLE_WIDTH  = 16;

   // Internal precision: extra fraction bits and headroom for the gain of about 1.65.
   localparam int GUARD        = 16;
   localparam int CORE_WIDTH   = DATA_WIDTH + GUARD + 3;

   // Phase accumulator in units of pi/2^31, wide enough for pi plus the sum of all arcs.
   localparam int PHASE_WIDTH  = 34;
   localparam int PHASE_SHIFT  = 16;
   localparam int TABLE_LEN    = 24;

   localparam int ITERATIONS_DEFAULT = 16;

   // Inverse CORDIC gain as a 32-bit fraction.
   localparam int GAIN_WIDTH = 32;
   localparam logic [GAIN_WIDTH-1:0] INV_GAIN = 32'h9B74EDA8;

   // Half and quarter turns.
   localparam logic signed [PHASE_WIDTH-1:0] HALF_TURN = 34'sh0_8000_0000;
   localparam logic signed [ANGLE_WIDTH-1:0] ANGLE_QUARTER = 16'sd16384;

   typedef enum logic {
      OP_TO_POLAR = 1'b0,
      OP_TO_RECT  = 1'b1
   } crdc_op_type;

   typedef struct packed {
      crdc_op_type                     operation;
      logic signed [DATA_WIDTH-1:0]    coord_x;
      logic signed [DATA_WIDTH-1:0]    coord_y;
      logic        [RADIUS_WIDTH-1:0]  radius;
      logic signed [ANGLE_WIDTH-1:0]   angle;
   } crdc_req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0]    result_x;
      logic signed [DATA_WIDTH-1:0]    result_y;
      logic        [DATA_WIDTH-1:0]    result_radius;
      logic signed [ANGLE_WIDTH-1:0]   result_angle;
   } crdc_rsp_type;

   // Control that travels alongside each request through the chain.
   typedef struct packed {
      logic        valid;
      crdc_op_type op;
      logic        zero;
   } crdc_ctrl_type;

   // Working vector and residual phase of one request.
   typedef struct packed {
      logic signed [CORE_WIDTH-1:0]  x;
      logic signed [CORE_WIDTH-1:0]  y;
      logic signed [PHASE_WIDTH-1:0] z;
   } crdc_vec_type;

   // atan(2^-i) in units of pi/2^31.
   function automatic logic signed [PHASE_WIDTH-1:0] arc_angle(input int unsigned idx);
      logic signed [PHASE_WIDTH-1:0] arc;
      case (idx)
         0:  arc = 34'sd536870912;
         1:  arc = 34'sd316933406;
         2:  arc = 34'sd167458907;
         3:  arc = 34'sd85004756;
         4:  arc = 34'sd42667331;
         5:  arc = 34'sd21354465;
         6:  arc = 34'sd10679838;
         7:  arc = 34'sd5340245;
         8:  arc = 34'sd2670163;
         9:  arc = 34'sd1335087;
         10: arc = 34'sd667544;
         11: arc = 34'sd333772;
         12: arc = 34'sd166886;
         13: arc = 34'sd83443;
         14: arc = 34'sd41722;
         15: arc = 34'sd20861;
         16: arc = 34'sd10430;
         17: arc = 34'sd5215;
         18: arc = 34'sd2608;
         19: arc = 34'sd1304;
         20: arc = 34'sd652;
         21: arc = 34'sd326;
         22: arc = 34'sd163;
         23: arc = 34'sd81;
         default: arc = '0;
      endcase
      return arc;
   endfunction

endpackage

// ===== hw/rtl/crdc_pre.sv =====
// Input stage: folds the request into a start vector and phase for the CORDIC chain.
module crdc_pre
   import crdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  logic          req_valid,
   input  crdc_req_type  req_data,
   output crdc_ctrl_type dn_ctrl,
   output crdc_vec_type  dn_vec
);

   localparam int PROD_WIDTH = RADIUS_WIDTH + GAIN_WIDTH;
   localparam int SHIFT_OUT  = GAIN_WIDTH - GUARD;

   crdc_ctrl_type ctrl_ff, ctrl_in;
   crdc_vec_type  vec_ff, vec_in;

   logic signed [CORE_WIDTH-1:0]  px, py, px_abs, py_abs;
   logic                          x_neg;
   logic        [PROD_WIDTH-1:0]  prod;
   logic        [PROD_WIDTH:0]    prod_rnd;
   logic        [CORE_WIDTH-1:0]  start_mag;
   logic signed [CORE_WIDTH-1:0]  start_x;
   logic signed [31:0]            ang_shift;
   logic signed [PHASE_WIDTH-1:0] ang_ext, rect_z;
   logic                          flip;

   // Vectoring start: move the point into the right half plane.
   always_comb begin
      px     = CORE_WIDTH'(req_data.coord_x);
      py     = CORE_WIDTH'(req_data.coord_y);
      x_neg  = req_data.coord_x[DATA_WIDTH-1];
      px_abs = x_neg ? -px : px;
      py_abs = x_neg ? -py : py;
   end

   // Rotation start: scale the radius by the inverse gain and fold the angle into +-pi/2.
   always_comb begin
      prod      = PROD_WIDTH'(req_data.radius) * PROD_WIDTH'(INV_GAIN);
      prod_rnd  = (PROD_WIDTH + 1)'(prod) + (PROD_WIDTH + 1)'(1 << (SHIFT_OUT - 1));
      start_mag = CORE_WIDTH'(prod_rnd[PROD_WIDTH:SHIFT_OUT]);
      ang_shift = {req_data.angle, {PHASE_SHIFT{1'b0}}};
      ang_ext   = PHASE_WIDTH'(ang_shift);
      flip      = (req_data.angle > ANGLE_QUARTER) || (req_data.angle < -ANGLE_QUARTER);
      if (req_data.angle > ANGLE_QUARTER) begin
         rect_z = ang_ext - HALF_TURN;
      end else if (req_data.angle < -ANGLE_QUARTER) begin
         rect_z = ang_ext + HALF_TURN;
      end else begin
         rect_z = ang_ext;
      end
      start_x = flip ? -signed'(start_mag) : signed'(start_mag);
   end

   // Select the start values by operation.
   always_comb begin
      ctrl_in.valid = req_valid;
      ctrl_in.op    = req_data.operation;
      ctrl_in.zero  = (req_data.operation == OP_TO_POLAR) &&
                      (req_data.coord_x == '0) && (req_data.coord_y == '0);
      if (req_data.operation == OP_TO_RECT) begin
         vec_in.x = start_x;
         vec_in.y = '0;
         vec_in.z = rect_z;
      end else begin
         vec_in.x = px_abs <<< GUARD;
         vec_in.y = py_abs <<< GUARD;
         vec_in.z = x_neg ? HALF_TURN : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= ctrl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_vec  = vec_ff;

endmodule

// ===== hw/rtl/crdc_cell.sv =====
// One CORDIC micro-rotation cell with its pipeline register.
module crdc_cell
   import crdc_pkg::*;
#(
   parameter int STAGE = 0
) (
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  crdc_ctrl_type up_ctrl,
   input  crdc_vec_type  up_vec,
   output crdc_ctrl_type dn_ctrl,
   output crdc_vec_type  dn_vec
);

   localparam logic signed [PHASE_WIDTH-1:0] ARC = arc_angle(STAGE);

   crdc_ctrl_type ctrl_ff;
   crdc_vec_type  vec_ff, vec_in;

   logic signed [CORE_WIDTH-1:0]  cx, cy, dx, dy;
   logic signed [PHASE_WIDTH-1:0] cz;
   logic                          ccw;

   // Rotation drives the phase to zero; vectoring drives y to zero.
   always_comb begin
      cx  = up_vec.x;
      cy  = up_vec.y;
      cz  = up_vec.z;
      dx  = cy >>> STAGE;
      dy  = cx >>> STAGE;
      ccw = (up_ctrl.op == OP_TO_RECT) ? !cz[PHASE_WIDTH-1] : cy[CORE_WIDTH-1];
      if (ccw) begin
         vec_in.x = cx - dx;
         vec_in.y = cy + dy;
         vec_in.z = cz - ARC;
      end else begin
         vec_in.x = cx + dx;
         vec_in.y = cy - dy;
         vec_in.z = cz + ARC;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= vec_in;
      end
   end

   assign dn_ctrl = ctrl_ff;
   assign dn_vec  = vec_ff;

endmodule

// ===== hw/rtl/crdc_post.sv =====
// Output stage: gain correction, rounding and saturation into the response fields.
module crdc_post
   import crdc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          advance,
   input  crdc_ctrl_type up_ctrl,
   input  crdc_vec_type  up_vec,
   output logic          dn_valid,
   output crdc_rsp_type  dn_data
);

   localparam int HI_WIDTH   = CORE_WIDTH - 1 - GAIN_WIDTH;
   localparam int PHI_WIDTH  = HI_WIDTH + GAIN_WIDTH;
   localparam int PLO_WIDTH  = 2 * GAIN_WIDTH;
   localparam int SUM_WIDTH  = PHI_WIDTH + 2;
   localparam int RAD_WIDTH  = SUM_WIDTH - GUARD;
   localparam int RECT_WIDTH = CORE_WIDTH - GUARD;

   crdc_ctrl_type ctrl_ff;
   crdc_vec_type  vec_ff;
   logic [PHI_WIDTH-1:0]  phi_ff, phi_in;
   logic [GAIN_WIDTH-1:0] plo_ff, plo_in;

   logic [CORE_WIDTH-1:0]         mag;
   logic [PLO_WIDTH-1:0]          plo_full;
   logic [SUM_WIDTH-1:0]          gain_sum, rad_rnd;
   logic [RAD_WIDTH-1:0]          rad_full;
   logic signed [PHASE_WIDTH-1:0] z_rnd;
   logic signed [CORE_WIDTH-1:0]  x_rnd, y_rnd;
   logic signed [RECT_WIDTH-1:0]  x_int, y_int;

   function automatic logic signed [DATA_WIDTH-1:0] clamp(input logic signed [RECT_WIDTH-1:0] v);
      logic signed [RECT_WIDTH-1:0] hi, lo;
      hi = RECT_WIDTH'({1'b0, {(DATA_WIDTH-1){1'b1}}});
      lo = -hi - RECT_WIDTH'(1);
      if (v > hi) begin
         return hi[DATA_WIDTH-1:0];
      end else if (v < lo) begin
         return lo[DATA_WIDTH-1:0];
      end
      return v[DATA_WIDTH-1:0];
   endfunction

   // Magnitude times the inverse gain, split into a high and a low partial product.
   always_comb begin
      mag      = up_vec.x[CORE_WIDTH-1] ? '0 : up_vec.x;
      phi_in   = PHI_WIDTH'(mag[CORE_WIDTH-2:GAIN_WIDTH]) * PHI_WIDTH'(INV_GAIN);
      plo_full = PLO_WIDTH'(mag[GAIN_WIDTH-1:0]) * PLO_WIDTH'(INV_GAIN);
      plo_in   = plo_full[PLO_WIDTH-1:GAIN_WIDTH];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ctrl_ff <= '0;
      end else if (advance) begin
         ctrl_ff <= up_ctrl;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         vec_ff <= up_vec;
         phi_ff <= phi_in;
         plo_ff <= plo_in;
      end
   end

   // Round and saturate into the response fields.
   always_comb begin
      gain_sum = SUM_WIDTH'(phi_ff) + SUM_WIDTH'(plo_ff);
      rad_rnd  = gain_sum + SUM_WIDTH'(1 << (GUARD - 1));
      rad_full = rad_rnd[SUM_WIDTH-1:GUARD];
      z_rnd    = vec_ff.z + PHASE_WIDTH'(1 << (PHASE_SHIFT - 1));
      x_rnd    = vec_ff.x + CORE_WIDTH'(1 << (GUARD - 1));
      y_rnd    = vec_ff.y + CORE_WIDTH'(1 << (GUARD - 1));
      x_int    = x_rnd[CORE_WIDTH-1:GUARD];
      y_int    = y_rnd[CORE_WIDTH-1:GUARD];
      dn_data  = '0;
      if (ctrl_ff.op == OP_TO_RECT) begin
         dn_data.result_x = clamp(x_int);
         dn_data.result_y = clamp(y_int);
      end else if (!ctrl_ff.zero) begin
         dn_data.result_radius = (rad_full > RAD_WIDTH'({DATA_WIDTH{1'b1}})) ?
                                 {DATA_WIDTH{1'b1}} : rad_full[DATA_WIDTH-1:0];
         dn_data.result_angle  = z_rnd[PHASE_SHIFT+ANGLE_WIDTH-1:PHASE_SHIFT];
      end
   end

   assign dn_valid = ctrl_ff.valid;

endmodule

// ===== hw/rtl/cartesian_polar_conversion.sv =====
// Top level of the pipelined CORDIC rectangular/polar converter.
//
//   channel   direction  handshake              payload
//   req       in         req_valid / req_ready  req_data  (crdc_req_type)
//   rsp       out        rsp_valid / rsp_ready  rsp_data  (crdc_rsp_type)
//
// One request enters per clock while the skid register is free; the chain of STAGES cells,
// the smaller of ITERATIONS and TABLE_LEN, holds one request per cell. A request passes
// through the input stage, the cells, the gain-product stage and the response register.
// Reset clears all valid bits; the datapath registers carry no reset.
// A stalled response is caught in a skid register, and the whole chain holds while it is full.
module cartesian_polar_conversion
   import crdc_pkg::*;
#(
   parameter int ITERATIONS = ITERATIONS_DEFAULT
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_valid,
   output logic         req_ready,
   input  crdc_req_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output crdc_rsp_type rsp_data
);

   localparam int STAGES = (ITERATIONS < TABLE_LEN) ? ITERATIONS : TABLE_LEN;

   crdc_ctrl_type ctrl_chain [0:STAGES];
   crdc_vec_type  vec_chain  [0:STAGES];

   logic         advance;
   logic         tail_valid;
   crdc_rsp_type tail_data;

   logic         rsp_valid_ff, rsp_valid_in;
   crdc_rsp_type rsp_data_ff, rsp_data_in;
   logic         skid_valid_ff, skid_valid_in;
   crdc_rsp_type skid_data_ff, skid_data_in;

   // The chain moves whenever the skid register is free.
   assign advance   = !skid_valid_ff;
   assign req_ready = advance;

   crdc_pre u_pre (
      .clock     (clock),
      .reset     (reset),
      .advance   (advance),
      .req_valid (req_valid),
      .req_data  (req_data),
      .dn_ctrl   (ctrl_chain[0]),
      .dn_vec    (vec_chain[0])
   );

   // Row of micro-rotation cells.
   for (genvar i = 0; i < STAGES; i++) begin : g_cell
      crdc_cell #(
         .STAGE (i)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .advance (advance),
         .up_ctrl (ctrl_chain[i]),
         .up_vec  (vec_chain[i]),
         .dn_ctrl (ctrl_chain[i+1]),
         .dn_vec  (vec_chain[i+1])
      );
   end

   crdc_post u_post (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .up_ctrl  (ctrl_chain[STAGES]),
      .up_vec   (vec_chain[STAGES]),
      .dn_valid (tail_valid),
      .dn_data  (tail_data)
   );

   // Response register with a skid register behind it.
   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      rsp_data_in   = rsp_data_ff;
      skid_valid_in = skid_valid_ff;
      skid_data_in  = skid_data_ff;
      if (rsp_valid_ff && rsp_ready) begin
         if (skid_valid_ff) begin
            rsp_data_in   = skid_data_ff;
            skid_valid_in = 1'b0;
         end else begin
            rsp_valid_in = 1'b0;
         end
      end
      if (advance && tail_valid) begin
         if (rsp_valid_ff && !rsp_ready) begin
            skid_valid_in = 1'b1;
            skid_data_in  = tail_data;
         end else begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = tail_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff  <= rsp_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff  <= rsp_data_in;
      skid_data_ff <= skid_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // The skid register is only ever occupied behind a waiting response.
   a_skid_behind_rsp: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> rsp_valid_ff)
      else $error("skid register full while response register is empty");

   // The skid register fills only when a response was stalled.
   a_skid_on_stall: assert property (@(posedge clock) disable iff (reset)
      $rose(skid_valid_ff) |-> $past(rsp_valid_ff && !rsp_ready))
      else $error("skid register filled without a stalled response");

   // A held skid entry keeps its contents.
   a_skid_holds: assert property (@(posedge clock) disable iff (reset)
      (skid_valid_ff && !rsp_ready) |=> (skid_valid_ff && $stable(skid_data_ff)))
      else $error("skid register changed while the response was stalled");

   // The zero-vector flag only ever travels with a rectangular-to-polar request.
   a_zero_polar: assert property (@(posedge clock) disable iff (reset)
      (ctrl_chain[0].valid && ctrl_chain[0].zero) |-> (ctrl_chain[0].op == OP_TO_POLAR))
      else $error("zero-vector flag set on a polar-to-rectangular request");

   // Vectoring keeps the working x in the right half plane.
   a_vector_x_positive: assert property (@(posedge clock) disable iff (reset)
      (ctrl_chain[STAGES].valid && ctrl_chain[STAGES].op == OP_TO_POLAR)
      |-> !vec_chain[STAGES].x[CORE_WIDTH-1])
      else $error("vectoring produced a negative magnitude");

endmodule

// ===== tb/cartesian_polar_conversion_test.sv =====
// Self-checking testbench for the CORDIC rectangular/polar converter with its own predictor.
module cartesian_polar_conversion_test
   import crdc_pkg::*;
;

   localparam int CORDIC_STEPS   = ITERATIONS_DEFAULT;
   localparam int STEPS_USED     = (CORDIC_STEPS < 24) ? CORDIC_STEPS : 24;
   localparam int LATENCY        = CORDIC_STEPS + 3;
   localparam int RANDOM_COUNT   = 900;
   localparam int WATCHDOG_LIMIT = 2000;

   localparam longint RIGHT_ANGLE = 64'sd1073741824;
   localparam longint HALF_CIRCLE = 64'sd2147483648;
   localparam longint unsigned GAIN_RECIPROCAL = 64'd2608131496;

   typedef struct {
      crdc_req_type data;
      bit           drain_first;
   } pending_request_type;

   logic         clock;
   logic         reset     = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_ready;
   crdc_req_type req_data  = '0;
   logic         rsp_valid;
   logic         rsp_ready = 1'b0;
   crdc_rsp_type rsp_data;

   // Arctangent steps atan(2^-i) in units of pi/2^31.
   longint arc_steps [0:23] = '{
      536870912, 316933406, 167458907, 85004756, 42667331, 21354465,
      10679838, 5340245, 2670163, 1335087, 667544, 333772,
      166886, 83443, 41722, 20861, 10430, 5215,
      2608, 1304, 652, 326, 163, 81
   };

   pending_request_type request_queue[$];
   crdc_rsp_type        expected_results[$];

   int  total_requests  = 0;
   int  accepted_count  = 0;
   int  checked_count   = 0;
   int  polar_count     = 0;
   int  rect_count      = 0;
   int  error_count     = 0;
   int  send_gap        = 0;
   int  hold_cycles     = 0;
   int  quiet_cycles    = 0;
   bit  long_hold_done  = 1'b0;

   cartesian_polar_conversion #(
      .ITERATIONS (CORDIC_STEPS)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Round away the guard bits and saturate to the signed sample range.
   function automatic logic [DATA_WIDTH-1:0] to_sample(longint value);
      longint rounded;
      rounded = (value + 32768) >>> 16;
      if (rounded > 32767) rounded = 32767;
      if (rounded < -32768) rounded = -32768;
      return rounded[DATA_WIDTH-1:0];
   endfunction

   // Expected response for one request, in either direction.
   function automatic crdc_rsp_type convert_coordinates(crdc_req_type rq);
      crdc_rsp_type      res;
      longint            x, y, z, cx, cy, dx, dy;
      longint unsigned   mag_raw, scaled, rounded, rad_u;
      bit                flip;
      int                step;
      res = '0;
      if (rq.operation == OP_TO_RECT) begin
         // Rotation mode: fold the angle into +-pi/2, then rotate toward zero residual.
         z = $signed(rq.angle);
         z = z * 65536;
         flip = 1'b0;
         if (z > RIGHT_ANGLE) begin
            z = z - HALF_CIRCLE;
            flip = 1'b1;
         end else if (z < -RIGHT_ANGLE) begin
            z = z + HALF_CIRCLE;
            flip = 1'b1;
         end
         rad_u = rq.radius;
         rounded = (rad_u * GAIN_RECIPROCAL + 64'd32768) >> 16;
         cx = rounded;
         if (flip) cx = -cx;
         cy = 0;
         for (step = 0; step < STEPS_USED; step++) begin
            dx = cy >>> step;
            dy = cx >>> step;
            if (z >= 0) begin
               cx = cx - dx;
               cy = cy + dy;
               z = z - arc_steps[step];
            end else begin
               cx = cx + dx;
               cy = cy - dy;
               z = z + arc_steps[step];
            end
         end
         res.result_x = to_sample(cx);
         res.result_y = to_sample(cy);
      end else begin
         // Vectoring mode: the zero vector gives zero magnitude and zero angle.
         x = $signed(rq.coord_x);
         y = $signed(rq.coord_y);
         if (x != 0 || y != 0) begin
            z = 0;
            if (x < 0) begin
               x = -x;
               y = -y;
               z = HALF_CIRCLE;
            end
            cx = x * 65536;
            cy = y * 65536;
            for (step = 0; step < STEPS_USED; step++) begin
               dx = cy >>> step;
               dy = cx >>> step;
               if (cy >= 0) begin
                  cx = cx + dx;
                  cy = cy - dy;
                  z = z + arc_steps[step];
               end else begin
                  cx = cx - dx;
                  cy = cy + dy;
                  z = z - arc_steps[step];
               end
            end
            mag_raw = 0;
            if (cx > 0) mag_raw = cx;
            // Gain correction done in two 32-bit halves, as the hardware does.
            scaled = (mag_raw >> 32) * GAIN_RECIPROCAL
                   + (((mag_raw & 64'hFFFF_FFFF) * GAIN_RECIPROCAL) >> 32);
            rounded = (scaled + 64'd32768) >> 16;
            if (rounded > 64'd65535) rounded = 64'd65535;
            res.result_radius = rounded[DATA_WIDTH-1:0];
            z = (z + 32768) >>> 16;
            res.result_angle = z[ANGLE_WIDTH-1:0];
         end
      end
      return res;
   endfunction

   // Coordinate values weighted toward the extremes and small magnitudes.
   function automatic logic [DATA_WIDTH-1:0] pick_coordinate();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 4))
               0: return 16'h7FFF;
               1: return 16'h8000;
               2: return 16'h0000;
               3: return 16'h0001;
               default: return 16'hFFFF;
            endcase
         end
         1, 2: return 16'(int'($urandom_range(0, 16)) - 8);
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [ANGLE_WIDTH-1:0] pick_angle();
      case ($urandom_range(0, 9))
         0: begin
            case ($urandom_range(0, 5))
               0: return 16'h8000;
               1: return 16'h7FFF;
               2: return 16'(16384 + int'($urandom_range(0, 2)) - 1);
               3: return 16'(-16384 + int'($urandom_range(0, 2)) - 1);
               4: return 16'h0000;
               default: return 16'hC000;
            endcase
         end
         default: return 16'($urandom());
      endcase
   endfunction

   function automatic logic [RADIUS_WIDTH-1:0] pick_radius();
      case ($urandom_range(0, 9))
         0: return ($urandom_range(0, 1) != 0) ? 15'h7FFF : 15'h0000;
         1, 2: return 15'($urandom_range(0, 16));
         default: return 15'($urandom());
      endcase
   endfunction

   // Append one request; fields the chosen direction does not use may hold any bits.
   task automatic queue_request(crdc_op_type op, logic [15:0] x, logic [15:0] y,
                                logic [14:0] r, logic [15:0] a, bit drain);
      pending_request_type entry;
      entry.data.operation = op;
      entry.data.coord_x   = x;
      entry.data.coord_y   = y;
      entry.data.radius    = r;
      entry.data.angle     = a;
      entry.drain_first    = drain;
      request_queue.push_back(entry);
   endtask

   // Stimulus, reset and the end of the run.
   initial begin
      // Directed part: range extremes, zero vector and the half-turn wrap.
      queue_request(OP_TO_POLAR, 16'h0000, 16'h0000, 15'h7FFF, 16'hFFFF, 1'b0);
      queue_request(OP_TO_POLAR, 16'h0000, 16'h0000, 15'h0000, 16'h0000, 1'b0);
      queue_request(OP_TO_POLAR, 16'h7FFF, 16'h0000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h8000, 16'h0000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'hFFFF, 16'h0000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h0001, 16'h0000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h0000, 16'h7FFF, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h0000, 16'h8000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h0000, 16'hFFFF, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h8000, 16'h8000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h7FFF, 16'h7FFF, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h8000, 16'h7FFF, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'h7FFF, 16'h8000, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_POLAR, 16'hFFFF, 16'hFFFF, pick_radius(), pick_angle(), 1'b0);
      queue_request(OP_TO_RECT, 16'hFFFF, 16'hFFFF, 15'h0000, 16'h0000, 1'b0);
      queue_request(OP_TO_RECT, 16'h0000, 16'h0000, 15'h7FFF, 16'h0000, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'h8000, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'h7FFF, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'h4000, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'hC000, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'h4001, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'hBFFF, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h7FFF, 16'h2000, 1'b0);
      queue_request(OP_TO_RECT, pick_coordinate(), pick_coordinate(), 15'h0001, 16'h3039, 1'b0);

      // Random part; the sender waits for the block to drain twice along the way.
      for (int n = 0; n < RANDOM_COUNT; n++) begin
         queue_request(crdc_op_type'($urandom_range(0, 1)), pick_coordinate(),
                       pick_coordinate(), pick_radius(), pick_angle(),
                       n == 0 || n == 620);
      end
      total_requests = request_queue.size();

      repeat (6) @(posedge clock);
      reset <= 1'b0;

      do @(posedge clock); while (request_queue.size() != 0 || req_valid);
      do @(posedge clock); while (expected_results.size() != 0);
      repeat (LATENCY + 4) @(posedge clock);

      $display("Checked %0d responses: %0d rectangular-to-polar, %0d polar-to-rectangular.",
               checked_count, polar_count, rect_count);
      $display("Stimulus spanned field extremes, the zero vector, the half-turn wrap, "
               , "random stalls on both sides and a long response back-pressure.");
      if (error_count == 0) begin
         $display("DONE: 0 errors");
      end else begin
         $display("DONE: errors detected");
      end
      $finish;
   end

   // Request driver: records a prediction for each accepted request, then offers the next.
   always @(posedge clock) begin : drive_requests
      logic offer;
      logic idle_ok;
      if (!reset) begin
         offer = req_valid;
         if (req_valid && req_ready) begin
            expected_results.push_back(convert_coordinates(req_data));
            if (req_data.operation == OP_TO_RECT) rect_count++;
            else polar_count++;
            accepted_count++;
            offer = 1'b0;
         end
         idle_ok = (accepted_count < 330 || accepted_count >= 520)
                   && accepted_count + 150 < total_requests;
         if (!offer) begin
            if (send_gap != 0) begin
               send_gap--;
            end else if (idle_ok && $urandom_range(0, 5) == 0) begin
               send_gap = $urandom_range(0, 12);
            end else if (request_queue.size() != 0 &&
                         !(request_queue[0].drain_first && expected_results.size() != 0)) begin
               req_data <= request_queue[0].data;
               request_queue.pop_front();
               offer = 1'b1;
            end
         end
         req_valid <= offer;
      end
   end

   task automatic report_mismatch(string field, logic [15:0] want, logic [15:0] got);
      error_count++;
      $display("%0t: %s mismatch, expected %h, got %h", $time, field, want, got);
   endtask

   // Response monitor and receiver stalls.
   always @(posedge clock) begin : collect_responses
      crdc_rsp_type want;
      logic         ready_next;
      logic         idle_ok;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            if (expected_results.size() == 0) begin
               error_count++;
               $display("%0t: response with no request outstanding, expected none, got %h",
                        $time, rsp_data);
            end else begin
               want = expected_results.pop_front();
               if (rsp_data.result_x !== want.result_x)
                  report_mismatch("result_x", want.result_x, rsp_data.result_x);
               if (rsp_data.result_y !== want.result_y)
                  report_mismatch("result_y", want.result_y, rsp_data.result_y);
               if (rsp_data.result_radius !== want.result_radius)
                  report_mismatch("result_radius", want.result_radius, rsp_data.result_radius);
               if (rsp_data.result_angle !== want.result_angle)
                  report_mismatch("result_angle", want.result_angle, rsp_data.result_angle);
               checked_count++;
            end
         end

         // One long hold lets the chain fill; short random holds elsewhere.
         idle_ok = (checked_count < 330 || checked_count >= 520)
                   && checked_count + 150 < total_requests;
         if (hold_cycles != 0) begin
            hold_cycles--;
            ready_next = 1'b0;
         end else if (!long_hold_done && checked_count >= 360) begin
            long_hold_done = 1'b1;
            hold_cycles = 99;
            ready_next = 1'b0;
         end else if (idle_ok && $urandom_range(0, 5) == 0) begin
            hold_cycles = $urandom_range(0, 12);
            ready_next = 1'b0;
         end else begin
            ready_next = 1'b1;
         end
         rsp_ready <= ready_next;
      end
   end

   // Watchdog: too long without any handshake on either channel ends the run.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Timeout after %0d cycles without a handshake.", quiet_cycles);
         $display("DONE: errors detected");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// ===== sim.f =====
hw/rtl/crdc_pkg.sv
hw/rtl/crdc_pre.sv
hw/rtl/crdc_cell.sv
hw/rtl/crdc_post.sv
hw/rtl/cartesian_polar_conversion.sv
tb/cartesian_polar_conversion_test.sv
